### hw/rtl/flac_linear_prediction_restore_core_macros.svh
// Assertion helpers for the restore core; all sample on clk and hold off during rst.
`ifndef FLAC_LINEAR_PREDICTION_RESTORE_CORE_MACROS_SVH
`define FLAC_LINEAR_PREDICTION_RESTORE_CORE_MACROS_SVH

// Same-cycle implication.
`define FLPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FLPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/flpr_pkg.sv
package flpr_pkg;

  localparam int MAX_ORDER   = 32;
  localparam int MAX_BLOCK   = 65536;
  localparam int FIXED_ORDER = 4;

  localparam int TAP_W    = $clog2(MAX_ORDER);
  localparam int ORDER_W  = 6;
  localparam int LEN_W    = 17;
  localparam int SHIFT_W  = 5;
  localparam int INDEX_W  = 5;
  localparam int VALUE_W  = 33;
  localparam int COEF_W   = 16;
  localparam int SAMPLE_W = 64;
  localparam int PROD_W   = VALUE_W + COEF_W;
  localparam int ACC_W    = PROD_W + TAP_W;
  localparam int SUM_W    = ACC_W + 1;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(4096);

  localparam logic [VALUE_W-1:0] SAT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] SAT_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef enum logic [2:0] {
    REG_KIND    = 3'd0,
    REG_ORDER   = 3'd1,
    REG_QSHIFT  = 3'd2,
    REG_WASTED  = 3'd3,
    REG_LENGTH  = 3'd4
  } reg_idx_t;

  typedef enum logic {
    OP_LOAD_COEF = 1'b0,
    OP_SAMPLE    = 1'b1
  } op_t;

  typedef enum logic {
    KIND_FIXED = 1'b0,
    KIND_LPC   = 1'b1
  } kind_t;

  // Sequencer steps, one control word each.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_CHECK = 3'd1,
    ST_MAC   = 3'd2,
    ST_DRAIN = 3'd3,
    ST_FIN   = 3'd4,
    ST_WR    = 3'd5
  } step_t;

  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_NO_SAMPLE = 3'd1,
    COND_SKIP_TAPS = 3'd2,
    COND_TAPS_LEFT = 3'd3,
    COND_OUT_BUSY  = 3'd4
  } cond_t;

  typedef struct packed {
    logic  in_ready;
    logic  clr;
    logic  mac;
    logic  drain;
    logic  fin;
    logic  wr;
    cond_t cond;
    step_t jump;
    step_t seq;
  } ctrl_t;

  localparam logic signed [3:0] FIXED_ROWS [FIXED_ORDER][FIXED_ORDER] = '{
    '{ 4'sd1,  4'sd0,  4'sd0,  4'sd0},
    '{ 4'sd2, -4'sd1,  4'sd0,  4'sd0},
    '{ 4'sd3, -4'sd3,  4'sd1,  4'sd0},
    '{ 4'sd4, -4'sd6,  4'sd4, -4'sd1}
  };

  function automatic logic signed [COEF_W-1:0] fixed_coef(input logic [1:0] row,
                                                          input logic [1:0] tap);
    logic signed [3:0] c;
    c = FIXED_ROWS[row][tap];
    return COEF_W'(c);
  endfunction

  // Microprogram: next step is jump when the condition holds, else seq.
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w = '{in_ready: 1'b0, clr: 1'b0, mac: 1'b0, drain: 1'b0, fin: 1'b0, wr: 1'b0,
          cond: COND_NEVER, jump: ST_IDLE, seq: ST_IDLE};
    case (s)
      ST_IDLE: begin
        w.in_ready = 1'b1;
        w.clr      = 1'b1;
        w.cond     = COND_NO_SAMPLE;
        w.jump     = ST_IDLE;
        w.seq      = ST_CHECK;
      end
      ST_CHECK: begin
        w.cond = COND_SKIP_TAPS;
        w.jump = ST_FIN;
        w.seq  = ST_MAC;
      end
      ST_MAC: begin
        w.mac  = 1'b1;
        w.cond = COND_TAPS_LEFT;
        w.jump = ST_MAC;
        w.seq  = ST_DRAIN;
      end
      ST_DRAIN: begin
        w.drain = 1'b1;
        w.seq   = ST_FIN;
      end
      ST_FIN: begin
        w.fin = 1'b1;
        w.seq = ST_WR;
      end
      ST_WR: begin
        w.wr   = 1'b1;
        w.cond = COND_OUT_BUSY;
        w.jump = ST_WR;
        w.seq  = ST_IDLE;
      end
      default: begin
        w.seq = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/flpr_if.sv
interface flpr_item_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [flpr_pkg::INDEX_W-1:0]        coef_index;
  logic signed [flpr_pkg::VALUE_W-1:0] value;

  modport source (output valid, operation, coef_index, value, input ready);
  modport sink (input valid, operation, coef_index, value, output ready);
endinterface

interface flpr_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [flpr_pkg::SAMPLE_W-1:0] sample;
  logic                                 block_end;

  modport source (output valid, sample, block_end, input ready);
  modport sink (input valid, sample, block_end, output ready);
endinterface

### hw/rtl/flac_linear_prediction_restore_core.sv
// Sample item: taken in idle, check, a MAC step per tap, drain, finish, writeback
// (result registered there; it waits while the output stalls), then back to idle; warmup
// samples and order 0 skip MAC and drain. Coefficient load items give no result.
// The tap loop uses one shared 33x16 multiplier, one tap per cycle.
// Synchronous reset clears configuration (block_length 4096), history, position and
// the sequencer; the coefficient table holds garbage until loaded.
`include "flac_linear_prediction_restore_core_macros.svh"

module flac_linear_prediction_restore_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [flpr_pkg::ADDR_W-1:0]  paddr,
  input  logic [flpr_pkg::DATA_W-1:0]  pwdata,
  output logic [flpr_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  flpr_item_if.sink                    item,
  flpr_result_if.source                result
);
  import flpr_pkg::*;

  // configuration
  logic               predictor_kind;
  logic [ORDER_W-1:0] predictor_order;
  logic [SHIFT_W-1:0] quant_shift;
  logic [SHIFT_W-1:0] wasted_bits;
  logic [LEN_W-1:0]   block_length;
  logic               cfg_write;
  reg_idx_t           cfg_sel;

  // sequencer
  step_t step, step_next;
  ctrl_t cw;
  logic  cond_hit;

  // datapath
  logic signed [VALUE_W-1:0]  history [MAX_ORDER];
  logic signed [COEF_W-1:0]   coef_table [MAX_ORDER];
  logic [LEN_W-1:0]           position;
  logic [TAP_W-1:0]           tap;
  logic signed [VALUE_W-1:0]  v_reg;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    shifted;
  logic signed [SUM_W-1:0]    sum;
  logic                       in_range;
  logic signed [VALUE_W-1:0]  s_fin;
  logic signed [VALUE_W-1:0]  s_reg;
  logic signed [COEF_W-1:0]   coef_sel;
  logic signed [COEF_W-1:0]   coef_rd;
  logic [ORDER_W-1:0]         order_eff;
  logic [ORDER_W-1:0]         order_m1;
  logic [LEN_W-1:0]           len_eff;
  logic [LEN_W-1:0]           pos_inc;
  logic                       warm;
  logic                       last;
  logic                       sample_acc;
  logic                       load_acc;
  logic                       out_busy;
  logic                       wr_fire;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_end;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_sel   = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_comb begin
    case (cfg_sel)
      REG_KIND:   prdata = DATA_W'(predictor_kind);
      REG_ORDER:  prdata = DATA_W'(predictor_order);
      REG_QSHIFT: prdata = DATA_W'(quant_shift);
      REG_WASTED: prdata = DATA_W'(wasted_bits);
      REG_LENGTH: prdata = DATA_W'(block_length);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      predictor_kind  <= KIND_FIXED;
      predictor_order <= '0;
      quant_shift     <= '0;
      wasted_bits     <= '0;
      block_length    <= LEN_RESET;
    end else if (cfg_write) begin
      case (cfg_sel)
        REG_KIND:   predictor_kind  <= pwdata[0];
        REG_ORDER:  predictor_order <= pwdata[ORDER_W-1:0];
        REG_QSHIFT: quant_shift     <= pwdata[SHIFT_W-1:0];
        REG_WASTED: wasted_bits     <= pwdata[SHIFT_W-1:0];
        REG_LENGTH: block_length    <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- derived settings ----------------
  always_comb begin
    if (predictor_kind == KIND_FIXED) begin
      order_eff = (predictor_order > ORDER_W'(FIXED_ORDER)) ? ORDER_W'(FIXED_ORDER)
                                                            : predictor_order;
    end else begin
      order_eff = (predictor_order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER)
                                                          : predictor_order;
    end
    if (block_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (block_length > LEN_W'(MAX_BLOCK)) begin
      len_eff = LEN_W'(MAX_BLOCK);
    end else begin
      len_eff = block_length;
    end
  end

  assign order_m1 = order_eff - ORDER_W'(1);
  assign warm     = position < LEN_W'(order_eff);
  assign pos_inc  = position + LEN_W'(1);
  assign last     = pos_inc >= len_eff;

  // ---------------- sequencer ----------------
  assign cw         = ucode(step);
  assign sample_acc = item.valid && cw.in_ready && (item.operation == OP_SAMPLE);
  assign load_acc   = item.valid && cw.in_ready && (item.operation == OP_LOAD_COEF);
  assign out_busy   = out_valid && !result.ready;
  assign wr_fire    = cw.wr && !out_busy;

  always_comb begin
    case (cw.cond)
      COND_NEVER:     cond_hit = 1'b0;
      COND_NO_SAMPLE: cond_hit = !sample_acc;
      COND_SKIP_TAPS: cond_hit = warm || (order_eff == '0);
      COND_TAPS_LEFT: cond_hit = ORDER_W'(tap) != order_m1;
      COND_OUT_BUSY:  cond_hit = out_busy;
      default:        cond_hit = 1'b0;
    endcase
    step_next = cond_hit ? cw.jump : cw.seq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // ---------------- coefficient table ----------------
  always_ff @(posedge clk) begin
    if (load_acc && (ORDER_W'(item.coef_index) < ORDER_W'(MAX_ORDER))) begin
      coef_table[item.coef_index[TAP_W-1:0]] <= item.value[COEF_W-1:0];
    end
    // Fetch one tap ahead so the registered word lines up with its MAC step.
    coef_rd <= coef_table[cw.mac ? tap + TAP_W'(1) : tap];
  end

  // ---------------- multiply-accumulate ----------------
  always_comb begin
    if (predictor_kind == KIND_FIXED) begin
      coef_sel = fixed_coef(order_m1[1:0], tap[1:0]);
    end else begin
      coef_sel = coef_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_acc) begin
      v_reg <= item.value;
    end
    if (cw.clr) begin
      acc  <= '0;
      prod <= '0;
      tap  <= '0;
    end else if (cw.mac) begin
      prod <= history[tap] * coef_sel;
      acc  <= acc + ACC_W'(prod);
      tap  <= tap + TAP_W'(1);
    end else if (cw.drain) begin
      acc <= acc + ACC_W'(prod);
    end
    if (cw.fin) begin
      s_reg <= s_fin;
    end
  end

  // ---------------- shift, residual add, saturate ----------------
  always_comb begin
    shifted  = (predictor_kind == KIND_LPC) ? (acc >>> quant_shift) : acc;
    sum      = SUM_W'(shifted) + SUM_W'(v_reg);
    in_range = (&sum[SUM_W-1:VALUE_W-1]) || !(|sum[SUM_W-1:VALUE_W-1]);
    if (warm) begin
      s_fin = v_reg;
    end else if (in_range) begin
      s_fin = sum[VALUE_W-1:0];
    end else begin
      s_fin = sum[SUM_W-1] ? SAT_MIN : SAT_MAX;
    end
  end

  // ---------------- history, position, output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ORDER; i++) begin
        history[i] <= '0;
      end
      position  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (wr_fire) begin
        for (int i = MAX_ORDER - 1; i > 0; i--) begin
          history[i] <= history[i-1];
        end
        history[0] <= s_reg;
        position   <= last ? '0 : pos_inc;
        out_valid  <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      out_sample <= SAMPLE_W'(s_reg) << wasted_bits;
      out_end    <= last;
    end
  end

  assign item.ready       = cw.in_ready;
  assign result.valid     = out_valid;
  assign result.sample    = out_sample;
  assign result.block_end = out_end;

  // ---------------- assertions ----------------
  `FLPR_ASSERT_NOW(a_tap_in_order, step == ST_MAC, ORDER_W'(tap) < order_eff, "tap past order")
  `FLPR_ASSERT_NEXT(a_load_stays_idle, load_acc, step == ST_IDLE, "load left idle")
  `FLPR_ASSERT_NEXT(a_block_restart, wr_fire && last, position == '0, "position not restarted")
  `FLPR_ASSERT_NOW(a_result_from_wr, $rose(result.valid), $past(step == ST_WR),
                   "result without writeback")

endmodule
